// ===== rtl/tpr_pkg.sv =====
// ----------------------------------------------------------------------------
// Telemetry poll responder package
// Shared types, codes and helper functions for the poll responder.
// ----------------------------------------------------------------------------
package tpr_pkg;

	localparam int MASK_W     = 10;
	localparam int NUM_STORED = 9;

	localparam logic ACT_POLL   = 1'b0;
	localparam logic ACT_UPDATE = 1'b1;

	localparam logic [3:0] KIND_TEMP     = 4'd0;
	localparam logic [3:0] KIND_RPM      = 4'd1;
	localparam logic [3:0] KIND_ALTITUDE = 4'd2;
	localparam logic [3:0] KIND_VSPEED   = 4'd3;
	localparam logic [3:0] KIND_PRESSURE = 4'd4;
	localparam logic [3:0] KIND_AIRSPEED = 4'd5;
	localparam logic [3:0] KIND_VOLTAGE  = 4'd6;
	localparam logic [3:0] KIND_CURRENT  = 4'd7;
	localparam logic [3:0] KIND_CAPACITY = 4'd8;

	localparam logic [7:0] ADDR_TEMP     = 8'h01;
	localparam logic [7:0] ADDR_RPM      = 8'h02;
	localparam logic [7:0] ADDR_VARIO    = 8'h03;
	localparam logic [7:0] ADDR_AIRSPEED = 8'h05;
	localparam logic [7:0] ADDR_BATTERY  = 8'h08;

	localparam logic [7:0] IDX_PLAIN    = 8'h00;
	localparam logic [7:0] IDX_ALTITUDE = 8'h03;
	localparam logic [7:0] IDX_VSPEED   = 8'h02;
	localparam logic [7:0] IDX_PRESSURE = 8'h01;
	localparam logic [7:0] IDX_CURRENT  = 8'h80;
	localparam logic [7:0] IDX_CAPACITY = 8'h08;

	localparam logic [7:0] HDR_MARK  = 8'hE0;
	localparam logic [7:0] LEN_BYTE  = 8'h03;
	localparam logic [7:0] CRC_POLY  = 8'h8C;

	localparam logic [1:0] ROT_FIRST  = 2'd0;
	localparam logic [1:0] ROT_SECOND = 2'd1;
	localparam logic [1:0] ROT_LAST   = 2'd2;

	// floor(x / 5) for x below 2**23 is (x * DIV5_MUL) >> DIV5_SHIFT
	localparam int          DIV5_SHIFT = 26;
	localparam logic [23:0] DIV5_MUL   = 24'd13421773;

	typedef enum logic [1:0] {
		SCL_UNIT,
		SCL_X10,
		SCL_X100,
		SCL_PRESS
	} scale_t;

	typedef logic [NUM_STORED-1:0][15:0] val_arr_t;

	typedef struct packed {
		logic [7:0] header_byte;
		logic [7:0] length_byte;
		logic [7:0] value_index;
		logic [7:0] value_high;
		logic [7:0] value_low;
		logic [7:0] crc_byte;
	} reply_bytes_t;

	typedef struct packed {
		logic         hit;
		reply_bytes_t bytes;
	} reply_t;

	function automatic scale_t kind_scale(input logic [3:0] kind);
		scale_t s;
		case (kind)
			KIND_ALTITUDE, KIND_VSPEED: s = SCL_X10;
			KIND_PRESSURE:              s = SCL_PRESS;
			KIND_VOLTAGE, KIND_CURRENT: s = SCL_X100;
			default:                    s = SCL_UNIT;
		endcase
		return s;
	endfunction

	function automatic logic [1:0] rot_next(input logic [1:0] r);
		return (r >= ROT_LAST) ? ROT_FIRST : r + 2'd1;
	endfunction

	// Dallas CRC-8, reflected, initial zero; first byte in the top bits
	function automatic logic [7:0] crc8_dallas(input logic [39:0] data);
		logic [7:0] crc;
		crc = 8'h00;
		for (int i = 0; i < 5; i++) begin
			crc = crc ^ data[39 - 8*i -: 8];
			for (int b = 0; b < 8; b++) begin
				crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
			end
		end
		return crc;
	endfunction

endpackage

// ===== rtl/tpr_item_if.sv =====
// ----------------------------------------------------------------------------
// Telemetry poll responder input channel
// Valid/ready channel carrying one poll or sensor update word.
// ----------------------------------------------------------------------------
interface tpr_item_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic [7:0]         poll_address;
	logic [3:0]         sensor_kind;
	logic signed [31:0] sensor_value;

	modport source (
		output valid, action, poll_address, sensor_kind, sensor_value,
		input  ready
	);
	modport sink (
		input  valid, action, poll_address, sensor_kind, sensor_value,
		output ready
	);
endinterface

// ===== rtl/tpr_reply_if.sv =====
// ----------------------------------------------------------------------------
// Telemetry poll responder reply channel
// Valid/ready channel carrying one six-byte reply word.
// ----------------------------------------------------------------------------
interface tpr_reply_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte;
	logic [7:0] length_byte;
	logic [7:0] value_index;
	logic [7:0] value_high;
	logic [7:0] value_low;
	logic [7:0] crc_byte;

	modport source (
		output valid, header_byte, length_byte, value_index, value_high,
		       value_low, crc_byte,
		input  ready
	);
	modport sink (
		input  valid, header_byte, length_byte, value_index, value_high,
		       value_low, crc_byte,
		output ready
	);
endinterface

// ===== rtl/tpr_scale.sv =====
// ----------------------------------------------------------------------------
// Telemetry poll responder value scaler
// Turns a signed Q24.8 reading into the 16-bit reported value, truncated
// toward zero.
// ----------------------------------------------------------------------------
module tpr_scale import tpr_pkg::*; (
	input  logic signed [31:0] value,
	input  scale_t             mode,
	output logic [15:0]        scaled
);

	logic        neg;
	logic [31:0] mag;
	logic [6:0]  mul;
	logic [38:0] prod;
	logic [46:0] prod_p;
	logic [15:0] q;

	assign neg    = value[31];
	assign mag    = neg ? (32'd0 - 32'(value)) : 32'(value);
	assign prod   = {7'd0, mag} * {32'd0, mul};
	assign prod_p = {24'd0, mag[31:9]} * {23'd0, DIV5_MUL};

	always_comb begin
		case (mode)
			SCL_X10:  mul = 7'd10;
			SCL_X100: mul = 7'd100;
			default:  mul = 7'd1;
		endcase
	end

	assign q      = (mode == SCL_PRESS) ? prod_p[DIV5_SHIFT +: 16] : prod[23:8];
	assign scaled = neg ? (16'd0 - q) : q;

endmodule

// ===== rtl/tpr_reply.sv =====
// ----------------------------------------------------------------------------
// Telemetry poll responder reply builder
// Decodes a poll address, picks the stored value and forms the reply bytes.
// ----------------------------------------------------------------------------
module tpr_reply import tpr_pkg::*; (
	input  logic [7:0]        addr,
	input  logic [MASK_W-1:0] mask,
	input  logic [1:0]        vario_rot,
	input  logic [1:0]        batt_rot,
	input  val_arr_t          vals,
	output reply_t            rsp
);

	logic [3:0]  kind;
	logic [7:0]  idx;
	logic        known;
	logic [15:0] val;

	always_comb begin
		known = 1'b1;
		kind  = KIND_TEMP;
		idx   = IDX_PLAIN;
		case (addr)
			ADDR_TEMP:     kind = KIND_TEMP;
			ADDR_RPM:      kind = KIND_RPM;
			ADDR_AIRSPEED: kind = KIND_AIRSPEED;
			ADDR_VARIO: begin
				case (vario_rot)
					ROT_FIRST: begin
						kind = KIND_ALTITUDE;
						idx  = IDX_ALTITUDE;
					end
					ROT_SECOND: begin
						kind = KIND_VSPEED;
						idx  = IDX_VSPEED;
					end
					default: begin
						kind = KIND_PRESSURE;
						idx  = IDX_PRESSURE;
					end
				endcase
			end
			ADDR_BATTERY: begin
				case (batt_rot)
					ROT_FIRST:  kind = KIND_VOLTAGE;
					ROT_SECOND: begin
						kind = KIND_CURRENT;
						idx  = IDX_CURRENT;
					end
					default: begin
						kind = KIND_CAPACITY;
						idx  = IDX_CAPACITY;
					end
				endcase
			end
			default: known = 1'b0;
		endcase
	end

	assign val = vals[kind];

	always_comb begin
		rsp.hit               = known && mask[kind];
		rsp.bytes.header_byte = addr | HDR_MARK;
		rsp.bytes.length_byte = LEN_BYTE;
		rsp.bytes.value_index = idx;
		rsp.bytes.value_high  = val[15:8];
		rsp.bytes.value_low   = val[7:0];
		rsp.bytes.crc_byte    = crc8_dallas({addr | HDR_MARK, LEN_BYTE, idx, val});
	end

endmodule

// ===== rtl/telemetry_poll_responder_top.sv =====
// ----------------------------------------------------------------------------
// Telemetry poll responder
// Answers one-byte telemetry polls from stored, pre-scaled sensor readings.
// ----------------------------------------------------------------------------
// One word is accepted every cycle unless the input stalls. A word is
// registered on entry and handled once the output can advance: an update scales
// the reading and stores the 16-bit result, a poll picks a stored value and
// lands its six-byte reply in the output register. Polls that get no reply still
// advance the vario and battery rotations. The input keeps taking words while a
// reply waits, and stalls only when both the input register and the output
// register are full. Readings are scaled once, on update, by a small constant
// multiply (and a reciprocal multiply for pressure); the reply path holds only
// selection and the CRC.
// ----------------------------------------------------------------------------
module telemetry_poll_responder_top import tpr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_wr_en,
	input  logic [MASK_W-1:0] cfg_wr_data,
	tpr_item_if.sink          item,
	tpr_reply_if.source       reply
);

	logic               valid_s1;
	logic               action_s1;
	logic [7:0]         addr_s1;
	logic [3:0]         kind_s1;
	logic signed [31:0] value_s1;

	logic [MASK_W-1:0]  mask_q;
	val_arr_t           vals_q;
	logic [1:0]         vario_rot_q;
	logic [1:0]         batt_rot_q;
	logic               out_valid_q;
	reply_bytes_t       out_q;

	logic               advance;
	logic               take;
	logic               fire;
	logic               poll;
	logic [15:0]        scaled;
	reply_t             rsp;

	assign advance    = !out_valid_q || reply.ready;
	assign item.ready = advance || !valid_s1;
	assign take       = item.valid && item.ready;
	assign fire       = valid_s1 && advance;
	assign poll       = action_s1 == ACT_POLL;

	tpr_scale u_scale (
		.value  (value_s1),
		.mode   (kind_scale(kind_s1)),
		.scaled (scaled)
	);

	tpr_reply u_reply (
		.addr      (addr_s1),
		.mask      (mask_q),
		.vario_rot (vario_rot_q),
		.batt_rot  (batt_rot_q),
		.vals      (vals_q),
		.rsp       (rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			action_s1 <= item.action;
			addr_s1   <= item.poll_address;
			kind_s1   <= item.sensor_kind;
			value_s1  <= item.sensor_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (cfg_wr_en) begin
			mask_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vals_q <= '0;
		end else if (fire && !poll && kind_s1 < 4'(NUM_STORED)) begin
			vals_q[kind_s1] <= scaled;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vario_rot_q <= ROT_FIRST;
			batt_rot_q  <= ROT_FIRST;
		end else if (fire && poll) begin
			if (addr_s1 == ADDR_VARIO) begin
				vario_rot_q <= rot_next(vario_rot_q);
			end
			if (addr_s1 == ADDR_BATTERY) begin
				batt_rot_q <= rot_next(batt_rot_q);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && poll && rsp.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= rsp.bytes;
		end
	end

	assign reply.valid       = out_valid_q;
	assign reply.header_byte = out_q.header_byte;
	assign reply.length_byte = out_q.length_byte;
	assign reply.value_index = out_q.value_index;
	assign reply.value_high  = out_q.value_high;
	assign reply.value_low   = out_q.value_low;
	assign reply.crc_byte    = out_q.crc_byte;

`ifndef SYNTHESIS
	a_rot_range: assert property (@(posedge clk) disable iff (!arst_n)
		vario_rot_q != 2'd3 && batt_rot_q != 2'd3)
		else $error("rotation counter out of range");

	a_reply_from_poll: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(fire && poll))
		else $error("reply without a handled poll");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> valid_s1 && out_valid_q && !reply.ready)
		else $error("input stalled without a full pipeline");

	a_update_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !poll |=> !$rose(out_valid_q))
		else $error("update produced a reply");
`endif

endmodule

// ===== sim/tb_telemetry_poll_responder_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Telemetry poll responder testbench
// Drives poll and sensor update words with random gaps and reply stalls.
// A scoreboard keeps its own copy of the readings, the rotations and the
// presence mask, predicts each six-byte reply with its CRC and checks every
// reply field by field. The mask is reloaded between phases.
// ----------------------------------------------------------------------------
module tb_telemetry_poll_responder_top;
	import tpr_pkg::*;

	localparam int          NUM_KINDS       = 10;
	localparam logic [3:0]  KIND_POWER      = 4'd9;
	localparam int          PHASE_WORDS     = 250;
	localparam int          SETTLE_CYCLES   = 4;
	localparam int          TAIL_CYCLES     = 8;
	localparam int          CYCLE_LIMIT     = 400000;
	localparam logic [MASK_W-1:0] MASK_ALL  = 10'h3FF;
	localparam logic [MASK_W-1:0] MASK_NONE = 10'h000;
	localparam logic [MASK_W-1:0] MASK_EVEN = 10'h155;
	localparam logic [MASK_W-1:0] MASK_ODD  = 10'h2AA;

	typedef struct {
		logic               action;
		logic [7:0]         poll_address;
		logic [3:0]         sensor_kind;
		logic signed [31:0] sensor_value;
	} item_word_t;

	class telemetry_reply_book;
		logic signed [31:0] sensor_readings [NUM_KINDS];
		logic [1:0]         vario_slot;
		logic [1:0]         battery_slot;
		logic [MASK_W-1:0]  sensor_mask;
		reply_bytes_t       awaited_replies [$];
		int                 fault_count;
		int                 replies_seen;

		function new();
			foreach (sensor_readings[k]) sensor_readings[k] = '0;
			vario_slot   = ROT_FIRST;
			battery_slot = ROT_FIRST;
			sensor_mask  = '0;
			fault_count  = 0;
			replies_seen = 0;
		endfunction

		function logic [15:0] scaled(logic [3:0] kind, longint mul, longint div);
			longint q;
			q = (longint'(sensor_readings[kind]) * mul) / div;
			return q[15:0];
		endfunction

		function logic [7:0] dallas_crc(logic [39:0] msg);
			logic [7:0] crc;
			logic [7:0] octet;
			logic       fb;
			crc = 8'h00;
			for (int i = 0; i < 5; i++) begin
				octet = msg[39 - 8*i -: 8];
				for (int j = 0; j < 8; j++) begin
					fb  = crc[0] ^ octet[j];
					crc = crc >> 1;
					if (fb) crc = crc ^ CRC_POLY;
				end
			end
			return crc;
		endfunction

		function logic [1:0] step_slot(logic [1:0] s);
			return (s >= ROT_LAST) ? ROT_FIRST : s + 2'd1;
		endfunction

		function void note_word(item_word_t w);
			reply_bytes_t r;
			logic [15:0]  level;
			logic [7:0]   idx;
			logic [3:0]   kind;
			logic [1:0]   slot;
			bit           answered;
			if (w.action == ACT_UPDATE) begin
				if (w.sensor_kind < NUM_KINDS) sensor_readings[w.sensor_kind] = w.sensor_value;
				return;
			end
			answered = 1'b1;
			idx      = IDX_PLAIN;
			level    = '0;
			kind     = KIND_TEMP;
			case (w.poll_address)
				ADDR_TEMP: begin
					kind  = KIND_TEMP;
					level = scaled(KIND_TEMP, 1, 256);
				end
				ADDR_RPM: begin
					kind  = KIND_RPM;
					level = scaled(KIND_RPM, 1, 256);
				end
				ADDR_AIRSPEED: begin
					kind  = KIND_AIRSPEED;
					level = scaled(KIND_AIRSPEED, 1, 256);
				end
				ADDR_VARIO: begin
					slot       = vario_slot;
					vario_slot = step_slot(vario_slot);
					case (slot)
						ROT_FIRST: begin
							kind  = KIND_ALTITUDE;
							idx   = IDX_ALTITUDE;
							level = scaled(KIND_ALTITUDE, 10, 256);
						end
						ROT_SECOND: begin
							kind  = KIND_VSPEED;
							idx   = IDX_VSPEED;
							level = scaled(KIND_VSPEED, 10, 256);
						end
						default: begin
							kind  = KIND_PRESSURE;
							idx   = IDX_PRESSURE;
							level = scaled(KIND_PRESSURE, 1, 2560);
						end
					endcase
				end
				ADDR_BATTERY: begin
					slot         = battery_slot;
					battery_slot = step_slot(battery_slot);
					case (slot)
						ROT_FIRST: begin
							kind  = KIND_VOLTAGE;
							level = scaled(KIND_VOLTAGE, 100, 256);
						end
						ROT_SECOND: begin
							kind  = KIND_CURRENT;
							idx   = IDX_CURRENT;
							level = scaled(KIND_CURRENT, 100, 256);
						end
						default: begin
							kind  = KIND_CAPACITY;
							idx   = IDX_CAPACITY;
							level = scaled(KIND_CAPACITY, 1, 256);
						end
					endcase
				end
				default: answered = 1'b0;
			endcase
			if (!answered || !sensor_mask[kind]) return;
			r.header_byte = w.poll_address | HDR_MARK;
			r.length_byte = LEN_BYTE;
			r.value_index = idx;
			r.value_high  = level[15:8];
			r.value_low   = level[7:0];
			r.crc_byte    = dallas_crc({r.header_byte, r.length_byte, r.value_index,
				r.value_high, r.value_low});
			awaited_replies.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s: expected %02h, got %02h", name, want, got);
				fault_count++;
			end
		endfunction

		function void check_reply(reply_bytes_t got);
			reply_bytes_t want;
			replies_seen++;
			if (awaited_replies.size() == 0) begin
				$error("reply %p arrived with none outstanding", got);
				fault_count++;
				return;
			end
			want = awaited_replies.pop_front();
			compare_field("header_byte", want.header_byte, got.header_byte);
			compare_field("length_byte", want.length_byte, got.length_byte);
			compare_field("value_index", want.value_index, got.value_index);
			compare_field("value_high",  want.value_high,  got.value_high);
			compare_field("value_low",   want.value_low,   got.value_low);
			compare_field("crc_byte",    want.crc_byte,    got.crc_byte);
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [MASK_W-1:0] cfg_wr_data;
	int                cycle_count = 0;
	int                words_sent = 0;
	int                masks_loaded = 0;
	bit                steady_flow = 1'b0;

	tpr_item_if  item_ch ();
	tpr_reply_if reply_ch ();

	telemetry_reply_book book;

	telemetry_poll_responder_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.item        (item_ch),
		.reply       (reply_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding",
				cycle_count, book.awaited_replies.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic item_word_t make_word(logic act, logic [7:0] addr, logic [3:0] kind,
		logic [31:0] val);
		item_word_t w;
		w.action       = act;
		w.poll_address = addr;
		w.sensor_kind  = kind;
		w.sensor_value = val;
		return w;
	endfunction

	function automatic logic [31:0] pick_reading();
		logic [31:0] v;
		case ($urandom_range(0, 3))
			0: v = 32'($urandom_range(0, 131071)) - 32'd65536;
			1: begin
				case ($urandom_range(0, 7))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'hFFFF_FFFF;
					3: v = 32'h0000_0000;
					4: v = 32'h0000_00FF;
					5: v = 32'hFFFF_FF01;
					6: v = 32'h0000_09FF;
					default: v = 32'hFFFF_F601;
				endcase
			end
			default: v = $urandom();
		endcase
		return v;
	endfunction

	function automatic item_word_t random_word();
		item_word_t w;
		int         r;
		w = make_word(ACT_POLL, 8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
			$urandom());
		r = $urandom_range(0, 99);
		if (r < 40) begin
			w.action       = ACT_UPDATE;
			w.sensor_kind  = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
				: 4'($urandom_range(0, NUM_KINDS - 1));
			w.sensor_value = pick_reading();
		end else if (r < 90) begin
			case ($urandom_range(0, 7))
				0:       w.poll_address = ADDR_TEMP;
				1:       w.poll_address = ADDR_RPM;
				2:       w.poll_address = ADDR_AIRSPEED;
				3, 4:    w.poll_address = ADDR_VARIO;
				default: w.poll_address = ADDR_BATTERY;
			endcase
		end
		return w;
	endfunction

	task automatic send_word(input item_word_t w);
		int gap;
		gap = steady_flow ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid        <= 1'b1;
		item_ch.action       <= w.action;
		item_ch.poll_address <= w.poll_address;
		item_ch.sensor_kind  <= w.sensor_kind;
		item_ch.sensor_value <= w.sensor_value;
		do @(posedge clk); while (!item_ch.ready);
		book.note_word(w);
		words_sent++;
	endtask

	task automatic settle(input int tail);
		while (book.awaited_replies.size() != 0) @(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic load_mask(input logic [MASK_W-1:0] m);
		settle(SETTLE_CYCLES);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= m;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		book.sensor_mask = m;
		masks_loaded++;
	endtask

	task automatic collect_replies();
		reply_bytes_t got;
		int           stall;
		forever begin
			stall = steady_flow ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				reply_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			reply_ch.ready <= 1'b1;
			do @(posedge clk); while (!reply_ch.valid);
			got.header_byte = reply_ch.header_byte;
			got.length_byte = reply_ch.length_byte;
			got.value_index = reply_ch.value_index;
			got.value_high  = reply_ch.value_high;
			got.value_low   = reply_ch.value_low;
			got.crc_byte    = reply_ch.crc_byte;
			book.check_reply(got);
		end
	endtask

	task automatic run_directed();
		send_word(make_word(ACT_POLL,   ADDR_TEMP,     KIND_TEMP,     32'h0));
		send_word(make_word(ACT_UPDATE, 8'hFF,         KIND_TEMP,     32'h7FFF_FFFF));
		send_word(make_word(ACT_POLL,   ADDR_TEMP,     4'hF,          32'hFFFF_FFFF));
		send_word(make_word(ACT_UPDATE, 8'h00,         KIND_RPM,      32'h8000_0000));
		send_word(make_word(ACT_POLL,   ADDR_RPM,      KIND_RPM,      32'h0));
		send_word(make_word(ACT_UPDATE, ADDR_VARIO,    KIND_ALTITUDE, 32'hFFFF_FFFF));
		send_word(make_word(ACT_UPDATE, ADDR_VARIO,    KIND_VSPEED,   32'h7FFF_FFFF));
		send_word(make_word(ACT_UPDATE, ADDR_VARIO,    KIND_PRESSURE, 32'h8000_0000));
		send_word(make_word(ACT_POLL,   ADDR_VARIO,    KIND_TEMP,     32'h0));
		send_word(make_word(ACT_POLL,   ADDR_VARIO,    KIND_TEMP,     32'h0));
		send_word(make_word(ACT_POLL,   ADDR_VARIO,    KIND_TEMP,     32'h0));
		send_word(make_word(ACT_UPDATE, ADDR_AIRSPEED, KIND_AIRSPEED, 32'hFFFF_FEFF));
		send_word(make_word(ACT_POLL,   ADDR_AIRSPEED, KIND_TEMP,     32'h0));
		send_word(make_word(ACT_UPDATE, ADDR_BATTERY,  KIND_VOLTAGE,  32'h1234_5678));
		send_word(make_word(ACT_UPDATE, ADDR_BATTERY,  KIND_CURRENT,  32'hFFFF_FC18));
		send_word(make_word(ACT_UPDATE, ADDR_BATTERY,  KIND_CAPACITY, 32'hFFFF_FF00));
		send_word(make_word(ACT_POLL,   ADDR_BATTERY,  KIND_TEMP,     32'h0));
		send_word(make_word(ACT_POLL,   ADDR_BATTERY,  KIND_TEMP,     32'h0));
		send_word(make_word(ACT_POLL,   ADDR_BATTERY,  KIND_TEMP,     32'h0));
		send_word(make_word(ACT_POLL,   ADDR_BATTERY,  KIND_TEMP,     32'h0));
		send_word(make_word(ACT_UPDATE, 8'h09,         KIND_POWER,    32'h5A5A_A5A5));
		send_word(make_word(ACT_UPDATE, 8'h00,         4'hF,          32'hDEAD_BEEF));
		send_word(make_word(ACT_POLL,   8'h00,         KIND_TEMP,     32'h0));
		send_word(make_word(ACT_POLL,   8'h04,         KIND_TEMP,     32'h0));
		send_word(make_word(ACT_POLL,   8'hFF,         KIND_TEMP,     32'h0));
		send_word(make_word(ACT_POLL,   ADDR_TEMP,     KIND_TEMP,     32'h0));
		item_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [MASK_W-1:0] mask_plan [7];
		book = new();
		mask_plan = '{MASK_ALL, MASK_NONE, MASK_W'($urandom_range(0, 1023)), MASK_EVEN,
			MASK_ODD, MASK_W'($urandom_range(0, 1023)), MASK_ALL};

		arst_n               <= 1'b0;
		cfg_wr_en            <= 1'b0;
		cfg_wr_data          <= '0;
		item_ch.valid        <= 1'b0;
		item_ch.action       <= ACT_POLL;
		item_ch.poll_address <= '0;
		item_ch.sensor_kind  <= '0;
		item_ch.sensor_value <= '0;
		reply_ch.ready       <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fork
			collect_replies();
		join_none

		load_mask(MASK_ALL);
		run_directed();

		foreach (mask_plan[p]) begin
			load_mask(mask_plan[p]);
			for (int n = 0; n < PHASE_WORDS; n++) begin
				if (n % 50 == 0) steady_flow = ($urandom_range(0, 3) == 0);
				if (n == PHASE_WORDS / 2 && p == 3) begin
					// hold input until every pending reply is back
					item_ch.valid <= 1'b0;
					settle(1);
				end
				send_word(random_word());
			end
			item_ch.valid <= 1'b0;
		end

		steady_flow = 1'b0;
		settle(TAIL_CYCLES);
		if (book.awaited_replies.size() != 0) begin
			$error("%0d replies never arrived", book.awaited_replies.size());
			book.fault_count++;
		end

		$display("Sent %0d words (polls and updates) under %0d presence masks;",
			words_sent, masks_loaded);
		$display("checked %0d replies, %0d field or ordering faults.",
			book.replies_seen, book.fault_count);
		if (book.fault_count == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
